[rtl/sks_pkg.sv]
// ----------------------------------------------------------------------------
// Stable key sorter package
// Shared types and codes for the stable key sorter controller and datapath.
// ----------------------------------------------------------------------------
package sks_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One stored entry: only the key takes part in the ordering.
  typedef struct packed {
    logic [15:0]        key;
    logic signed [15:0] payload;
  } pair_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;     // latch the item and prime the insert cursor
    logic    rd_head;    // read the oldest smallest entry
    logic    rd_prev;    // read the entry below the insert cursor
    logic    wr_new;     // write the new pair at the cursor and grow the store
    logic    wr_shift;   // move the read entry up one place and step the cursor down
    logic    emit;       // present a result next cycle
    status_e emit_st;    // status of that result
    logic    emit_data;  // result carries the read entry
    logic    pop;        // drop the head entry
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic rem_zero;      // no held entry left below the cursor
    logic greater;       // read entry key is greater than the new key
  } stat_t;

endpackage

[rtl/sks_datapath.sv]
// ----------------------------------------------------------------------------
// Stable key sorter datapath
// Circular sorted store in one memory, head and count registers, the insert
// cursor and the registered result outputs.
// ----------------------------------------------------------------------------
module sks_datapath #(
  parameter int CAPACITY = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sks_pkg::cmd_t      cmd_i,
  output sks_pkg::stat_t     stat_o,
  input  logic [15:0]        sort_key_i,
  input  logic signed [15:0] payload_i,
  output logic               done_o,
  output logic [15:0]        out_key_o,
  output logic signed [15:0] out_payload_o,
  output logic [1:0]         status_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  sks_pkg::pair_t mem_q [CAPACITY];
  sks_pkg::pair_t rd_data_q;
  sks_pkg::pair_t wr_data;
  sks_pkg::pair_t new_pair;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [15:0]        key_q;
  logic signed [15:0] pay_q;
  logic          done_q;
  logic [15:0]        okey_q;
  logic signed [15:0] opay_q;
  logic [1:0]    ost_q;

  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_wrap;
  logic [AW-1:0] prev_pos;
  logic [AW-1:0] next_head;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;

  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign tail_wrap = (tail_sum >= SW'(CAPACITY)) ? (tail_sum - SW'(CAPACITY)) : tail_sum;
  assign prev_pos  = (pos_q == '0) ? AW'(CAPACITY - 1) : (pos_q - 1'b1);
  assign next_head = (head_q == AW'(CAPACITY - 1)) ? '0 : (head_q + 1'b1);

  assign new_pair.key     = key_q;
  assign new_pair.payload = pay_q;
  assign wr_data = cmd_i.wr_new ? new_pair : rd_data_q;
  assign wr_en   = cmd_i.wr_new | cmd_i.wr_shift;
  assign rd_en   = cmd_i.rd_head | cmd_i.rd_prev;
  assign rd_addr = cmd_i.rd_head ? head_q : prev_pos;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pos_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    if (cmd_i.accept) begin
      pos_d = tail_wrap[AW-1:0];
      rem_d = count_q;
    end
    if (cmd_i.wr_shift) begin
      pos_d = prev_pos;
      rem_d = rem_q - 1'b1;
    end
    if (cmd_i.wr_new) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d  = next_head;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      rem_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      done_q  <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= sort_key_i;
      pay_q <= payload_i;
    end
    if (cmd_i.emit) begin
      ost_q  <= cmd_i.emit_st;
      okey_q <= cmd_i.emit_data ? rd_data_q.key : '0;
      opay_q <= cmd_i.emit_data ? rd_data_q.payload : '0;
    end
  end

  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.greater  = (rd_data_q.key > key_q);

  assign done_o        = done_q;
  assign out_key_o     = okey_q;
  assign out_payload_o = opay_q;
  assign status_o      = ost_q;

endmodule

[rtl/sks_ctrl.sv]
// ----------------------------------------------------------------------------
// Stable key sorter controller
// One-hot state machine that sequences inserts and removals over the datapath.
// ----------------------------------------------------------------------------
module sks_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           opcode_i,
  input  sks_pkg::stat_t stat_i,
  output sks_pkg::cmd_t  cmd_o,
  output logic           busy
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_INS_RD  = 4'b0010,
    S_INS_CMP = 4'b0100,
    S_REM_OUT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_st = sks_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == sks_pkg::OP_INSERT) begin
            if (stat_i.full) begin
              cmd_o.emit    = 1'b1;
              cmd_o.emit_st = sks_pkg::ST_FULL;
            end else begin
              state_d = S_INS_RD;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.emit    = 1'b1;
              cmd_o.emit_st = sks_pkg::ST_EMPTY;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = S_REM_OUT;
            end
          end
        end
      end
      S_INS_RD: begin
        if (stat_i.rem_zero) begin
          cmd_o.wr_new = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat_i.greater) begin
          cmd_o.wr_shift = 1'b1;
          state_d        = S_INS_RD;
        end else begin
          cmd_o.wr_new = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_REM_OUT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_data = 1'b1;
        cmd_o.pop       = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

[rtl/stable_key_sorter_top.sv]
// ----------------------------------------------------------------------------
// Stable key sorter
// Holds up to CAPACITY key/payload pairs and returns them smallest key first,
// equal keys in arrival order.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low, and every item gives
// exactly one result, shown for a single cycle with done_o high. The receiver
// cannot stall the block, so results must be captured in the cycle they
// appear. A flagged item (insert while full, remove while empty) gives its
// result in the next cycle and busy stays low, so a new item may follow at
// once. An insert moves every held pair with a key greater than the new one
// up one place, one step per pair: each step reads one entry, compares it on
// the next cycle and moves it up if its key is greater. The insert stops on
// a smaller or equal key or when no pair is left to compare. The store is a
// circular buffer, so a removal just reads the head.
// No clearing pass is needed after reset; the store is empty at once.
// ----------------------------------------------------------------------------
module stable_key_sorter_top #(
  parameter int CAPACITY = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [15:0]        sort_key_i,
  input  logic signed [15:0] payload_i,
  output logic               done_o,
  output logic [15:0]        out_key_o,
  output logic signed [15:0] out_payload_o,
  output logic [1:0]         status_o
);

  sks_pkg::cmd_t  cmd;
  sks_pkg::stat_t stat;

  // The controller decides each step; the datapath owns all storage.
  sks_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  sks_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .sort_key_i    (sort_key_i),
    .payload_i     (payload_i),
    .done_o        (done_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .status_o      (status_o)
  );

  // A result only ever leaves while the controller is back in its idle state.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result transfer while busy");

  // An accepted item either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted item neither answered nor in progress");

  // A flagged result carries no pair.
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != sks_pkg::ST_OK)) |-> (out_key_o == '0 && out_payload_o == '0))
    else $error("flagged result carries data");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Stable key sorter testbench
// Drives insert and remove commands into the sorter and checks every result
// against a behavioral model of the sorted store. The run is a short directed
// part, then random load and drain sequences, then a fill to capacity.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 512;

  // One expected result, in the shape of the result ports.
  typedef struct {
    logic [15:0]        key;
    logic signed [15:0] payload;
    sks_pkg::status_e   status;
  } sorter_result_t;

  // Behavioral copy of the sorted store. Entry 0 of held_pairs is the next
  // pair to leave. Each accepted command queues the result it must produce.
  class sorted_store_model;
    int                 capacity;
    int                 errors;
    sks_pkg::pair_t     held_pairs[$];
    sorter_result_t     pending_results[$];

    function new(int cap);
      capacity = cap;
      errors   = 0;
    endfunction

    function void note_item(sks_pkg::op_e op, logic [15:0] key, logic signed [15:0] pay);
      sorter_result_t r;
      sks_pkg::pair_t p;
      int             pos;
      r.key     = '0;
      r.payload = '0;
      r.status  = sks_pkg::ST_OK;
      if (op == sks_pkg::OP_INSERT) begin
        if (held_pairs.size() >= capacity) begin
          r.status = sks_pkg::ST_FULL;
        end else begin
          // The new pair goes after every held key that is not greater, which
          // keeps equal keys in arrival order.
          pos = held_pairs.size();
          while (pos > 0 && held_pairs[pos-1].key > key) pos--;
          p.key     = key;
          p.payload = pay;
          held_pairs.insert(pos, p);
        end
      end else if (held_pairs.size() == 0) begin
        r.status = sks_pkg::ST_EMPTY;
      end else begin
        p         = held_pairs.pop_front();
        r.key     = p.key;
        r.payload = p.payload;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [15:0] key, logic signed [15:0] pay,
                               logic [1:0] status);
      sorter_result_t r;
      if (pending_results.size() == 0) begin
        $error("unexpected result: key %0h payload %0h status %0d", key, pay, status);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      if (status !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, status);
        errors++;
      end
      if (key !== r.key) begin
        $error("out_key mismatch: expected %0h, actual %0h", r.key, key);
        errors++;
      end
      if (pay !== r.payload) begin
        $error("out_payload mismatch: expected %0h, actual %0h", r.payload, pay);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode_i = 1'b0;
  logic [15:0]        sort_key_i = '0;
  logic signed [15:0] payload_i = '0;
  logic               done_o;
  logic [15:0]        out_key_o;
  logic signed [15:0] out_payload_o;
  logic [1:0]         status_o;

  sorted_store_model  store_model = new(CAPACITY);

  // When set, the command side inserts short idle bursts before transfers.
  bit allow_gaps = 1'b0;
  int items_sent = 0;

  stable_key_sorter_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .sort_key_i   (sort_key_i),
    .payload_i    (payload_i),
    .done_o       (done_o),
    .out_key_o    (out_key_o),
    .out_payload_o(out_payload_o),
    .status_o     (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Results cannot be held off, so every cycle with done_o high is a transfer.
  // The values read right after the edge are the ones that stood during the
  // cycle that this edge closes.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      store_model.check_result(out_key_o, out_payload_o, status_o);
    end
  end

  // Presents one command and returns at the edge where it is transferred,
  // that is where start is high and busy is low. The caller may then present
  // the next command in the same time step without start dropping in between.
  task automatic send_item(sks_pkg::op_e op, logic [15:0] key, logic signed [15:0] pay);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start      <= 1'b1;
    opcode_i   <= op;
    sort_key_i <= key;
    payload_i  <= pay;
    do @(posedge clk_i); while (busy);
    store_model.note_item(op, key, pay);
    items_sent++;
  endtask

  // A hung block must not keep the run alive; this bound sits well above the
  // slowest correct run of this stimulus.
  initial begin
    #40_000_000;
    $display("** stable_key_sorter_top: FAILED **");
    $finish;
  end

  initial begin
    int          n;
    int          m;
    bit          narrow;
    logic [15:0] base;
    logic [15:0] ramp;
    logic [15:0] key;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, back to back. A remove on the empty store comes first,
    // with its key and payload fields set to values that must be ignored.
    send_item(sks_pkg::OP_REMOVE, 16'hFFFF, 16'sh7FFF);
    // Key and payload extremes, then equal keys at both ends of the range so
    // that stability shows in the drain order.
    send_item(sks_pkg::OP_INSERT, 16'h0000, 16'sh8000);
    send_item(sks_pkg::OP_INSERT, 16'hFFFF, 16'sh7FFF);
    send_item(sks_pkg::OP_INSERT, 16'hFFFF, 16'sh0001);
    send_item(sks_pkg::OP_INSERT, 16'h8000, -16'sd1);
    send_item(sks_pkg::OP_INSERT, 16'h0000, 16'sh1234);
    send_item(sks_pkg::OP_INSERT, 16'h5555, 16'sh2AAA);
    send_item(sks_pkg::OP_INSERT, 16'hAAAA, 16'sh5555);
    // Drain everything, with live-looking fields that the block must ignore.
    repeat (7) send_item(sks_pkg::OP_REMOVE, 16'($urandom), 16'($urandom));
    // The store is empty again, so this remove is flagged too.
    send_item(sks_pkg::OP_REMOVE, 16'h0000, 16'sh0000);

    // Random part: mostly a load of random pairs followed by removals, with
    // the keys sometimes drawn from a narrow window so that equal keys are
    // common. Some sequences drain past empty, some leave pairs behind for
    // the next load to sort against. One in ten steps is a lone random item.
    while (items_sent < 300) begin
      allow_gaps = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        send_item(sks_pkg::op_e'(1'($urandom_range(0, 1))), 16'($urandom),
                  16'($urandom));
      end else begin
        n      = $urandom_range(1, 16);
        narrow = 1'($urandom_range(0, 1));
        base   = 16'($urandom);
        for (int i = 0; i < n; i++) begin
          key = narrow ? base + 16'($urandom_range(0, 3)) : 16'($urandom);
          send_item(sks_pkg::OP_INSERT, key, 16'($urandom));
        end
        m = $urandom_range(0, 1) ? $urandom_range(n, n + 2) : $urandom_range(1, n);
        for (int i = 0; i < m; i++) begin
          send_item(sks_pkg::OP_REMOVE, 16'($urandom), 16'($urandom));
        end
      end
    end

    // Last part, with no idling: empty the store, then fill it to capacity
    // with a slowly rising key ramp (runs of equal keys included) and the odd
    // random key that must sort deep into the store.
    allow_gaps = 1'b0;
    while (store_model.held_pairs.size() > 0) begin
      send_item(sks_pkg::OP_REMOVE, 16'($urandom), 16'($urandom));
    end
    ramp = 16'h0000;
    while (store_model.held_pairs.size() < CAPACITY) begin
      key = ($urandom_range(0, 15) == 0) ? 16'($urandom) : ramp;
      send_item(sks_pkg::OP_INSERT, key, 16'($urandom));
      ramp = ramp + 16'($urandom_range(0, 3));
    end
    // Inserts into the full store are dropped and flagged.
    repeat (3) send_item(sks_pkg::OP_INSERT, 16'($urandom), 16'($urandom));
    // One slot opens and is taken again, then the store is full once more.
    send_item(sks_pkg::OP_REMOVE, 16'($urandom), 16'($urandom));
    send_item(sks_pkg::OP_INSERT, 16'hFFFF, 16'($urandom));
    send_item(sks_pkg::OP_INSERT, 16'h0000, 16'($urandom));
    repeat (40) send_item(sks_pkg::OP_REMOVE, 16'($urandom), 16'($urandom));
    start <= 1'b0;

    // Every command gives exactly one result, so once none is pending only
    // a short settle time is needed to catch any stray result.
    while (store_model.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (store_model.errors == 0 && store_model.pending_results.size() == 0) begin
      $display("** stable_key_sorter_top: PASSED **");
    end else begin
      $display("** stable_key_sorter_top: FAILED **");
    end
    $finish;
  end

endmodule
